>>> src/acs_pkg.sv
// shared types and constants of the accumulator processor step block
package acs_pkg;

	// memory geometry
	localparam int MEM_BYTES = 4096;
	localparam int ADDR_W    = $clog2(MEM_BYTES);

	// request operation codes
	typedef enum logic [1:0] {
		REQ_WRITE = 2'd0,
		REQ_READ  = 2'd1,
		REQ_STEP  = 2'd2
	} req_op_t;

	// instruction opcodes
	typedef enum logic [3:0] {
		OPC_HALT  = 4'h0,
		OPC_NOT   = 4'h1,
		OPC_SHL   = 4'h2,
		OPC_SAR   = 4'h3,
		OPC_INC   = 4'h4,
		OPC_DEC   = 4'h5,
		OPC_JMP   = 4'h6,
		OPC_JAZ   = 4'h7,
		OPC_LOAD  = 4'h8,
		OPC_STORE = 4'h9,
		OPC_ADD   = 4'hA,
		OPC_AND   = 4'hB,
		OPC_OR    = 4'hC,
		OPC_XOR   = 4'hD,
		OPC_OUT   = 4'hE,
		OPC_IN    = 4'hF
	} opcode_t;

	// output format codes
	localparam logic [1:0] FMT_CHAR = 2'd2;

	// one input request
	typedef struct packed {
		logic [1:0]        operation;
		logic [ADDR_W-1:0] address;
		logic [7:0]        byte_data;
		logic [15:0]       in_value;
	} item_t;

	// one result
	typedef struct packed {
		logic [7:0]        read_data;
		logic              halted;
		logic              in_used;
		logic              out_valid;
		logic signed [15:0] out_value;
		logic [1:0]        out_format;
		logic [ADDR_W-1:0] pc_now;
		logic signed [15:0] acc_now;
	} res_t;

	// execute unit outcome
	typedef struct packed {
		logic [15:0]       acc;
		logic [ADDR_W-1:0] pc;
		logic              halted;
		logic              in_used;
		logic              out_valid;
		logic [15:0]       out_value;
		logic [1:0]        out_format;
	} alu_res_t;

	// sequencer status toward the request and result registers
	typedef struct packed {
		logic take;
		logic res_load;
		logic clearing;
	} seq_stat_t;

endpackage

>>> src/acs_ram.sv
// generic single-port synchronous ram with registered read
module acs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// one access per cycle, read data holds until the next read
	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem_q[addr] <= wdata;
			end else begin
				rdata_q <= mem_q[addr];
			end
		end
	end

	assign rdata = rdata_q;

endmodule

>>> src/acs_alu.sv
// instruction execute unit: next accumulator, next pc and output flags
module acs_alu (
	input  acs_pkg::opcode_t                opcode,
	input  logic [acs_pkg::ADDR_W-1:0]      operand,
	input  logic [15:0]                     acc,
	input  logic [acs_pkg::ADDR_W-1:0]      pc,
	input  logic [15:0]                     word,
	input  logic [15:0]                     in_value,
	output acs_pkg::alu_res_t               res
);

	logic big_shift;

	// shift counts of 16 and above saturate
	assign big_shift = (operand[acs_pkg::ADDR_W-1:4] != '0);

	always_comb begin
		res            = '0;
		res.acc        = acc;
		res.pc         = pc + acs_pkg::ADDR_W'(2);
		unique case (opcode)
			acs_pkg::OPC_HALT:  res.halted = 1'b1;
			acs_pkg::OPC_NOT:   res.acc = ~acc;
			acs_pkg::OPC_SHL:   res.acc = big_shift ? 16'd0 : (acc << operand[3:0]);
			acs_pkg::OPC_SAR: begin
				res.acc = big_shift ? {16{acc[15]}}
				                    : 16'($signed(acc) >>> operand[3:0]);
			end
			acs_pkg::OPC_INC:   res.acc = acc + 16'd1;
			acs_pkg::OPC_DEC:   res.acc = acc - 16'd1;
			acs_pkg::OPC_JMP:   res.pc = operand;
			acs_pkg::OPC_JAZ: begin
				if (acc == 16'd0) begin
					res.pc = operand;
				end
			end
			acs_pkg::OPC_LOAD:  res.acc = word;
			acs_pkg::OPC_STORE: res.acc = acc;
			acs_pkg::OPC_ADD:   res.acc = acc + word;
			acs_pkg::OPC_AND:   res.acc = acc & word;
			acs_pkg::OPC_OR:    res.acc = acc | word;
			acs_pkg::OPC_XOR:   res.acc = acc ^ word;
			acs_pkg::OPC_OUT: begin
				res.out_valid  = 1'b1;
				res.out_value  = acc;
				res.out_format = (operand[acs_pkg::ADDR_W-1:1] != '0) ? acs_pkg::FMT_CHAR
				                                                       : operand[1:0];
			end
			acs_pkg::OPC_IN: begin
				res.acc     = in_value;
				res.in_used = 1'b1;
			end
		endcase
	end

endmodule

>>> src/acs_seq.sv
// sequencer: memory clearing pass, fetch, operand access and write back
module acs_seq (
	input  logic                 clk,
	input  logic                 arst_n,
	input  acs_pkg::item_t       item,
	input  logic                 item_full,
	input  logic                 out_free,
	output acs_pkg::res_t        res,
	output acs_pkg::seq_stat_t   stat
);

	typedef enum logic [7:0] {
		S_CLEAR    = 8'b0000_0001,
		S_IDLE     = 8'b0000_0010,
		S_RD_DATA  = 8'b0000_0100,
		S_FETCH_HI = 8'b0000_1000,
		S_DECODE   = 8'b0001_0000,
		S_OPER_HI  = 8'b0010_0000,
		S_OPER_DAT = 8'b0100_0000,
		S_STORE_HI = 8'b1000_0000
	} state_t;

	localparam int AW = acs_pkg::ADDR_W;
	localparam logic [AW-1:0] LAST_ADDR = AW'(acs_pkg::MEM_BYTES - 1);

	state_t            state_q, state_d;
	logic [AW-1:0]     clr_q;
	logic [AW-1:0]     pc_q, pc_d;
	logic [15:0]       acc_q, acc_d;
	logic [7:0]        lo_q, lo_d;
	acs_pkg::opcode_t  opcode_q;
	logic [AW-1:0]     operand_q;
	logic [15:0]       inval_q;

	logic              ram_en, ram_we;
	logic [AW-1:0]     ram_addr;
	logic [7:0]        ram_wdata, ram_rdata;

	logic [15:0]       insn;
	acs_pkg::opcode_t  insn_opc;
	acs_pkg::opcode_t  alu_opc;
	logic [AW-1:0]     alu_operand;
	logic              mem_read_op;
	acs_pkg::alu_res_t alu_res;
	acs_pkg::res_t     step_res;

	acs_ram #(
		.WIDTH (8),
		.DEPTH (acs_pkg::MEM_BYTES)
	) u_ram (
		.clk   (clk),
		.en    (ram_en),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	// instruction word: high byte just read, low byte from the previous read
	assign insn     = {ram_rdata, lo_q};
	assign insn_opc = acs_pkg::opcode_t'(insn[15:12]);

	assign mem_read_op = (insn_opc == acs_pkg::OPC_LOAD) || (insn_opc == acs_pkg::OPC_ADD) ||
	                     (insn_opc == acs_pkg::OPC_AND)  || (insn_opc == acs_pkg::OPC_OR)  ||
	                     (insn_opc == acs_pkg::OPC_XOR);

	// decode uses the fresh word, later states the saved one
	assign alu_opc     = (state_q == S_DECODE) ? insn_opc : opcode_q;
	assign alu_operand = (state_q == S_DECODE) ? insn[AW-1:0] : operand_q;

	acs_alu u_alu (
		.opcode   (alu_opc),
		.operand  (alu_operand),
		.acc      (acc_q),
		.pc       (pc_q),
		.word     (insn),
		.in_value (inval_q),
		.res      (alu_res)
	);

	// result of a finished instruction
	always_comb begin
		step_res            = '0;
		step_res.halted     = alu_res.halted;
		step_res.in_used    = alu_res.in_used;
		step_res.out_valid  = alu_res.out_valid;
		step_res.out_value  = alu_res.out_value;
		step_res.out_format = alu_res.out_format;
		step_res.pc_now     = alu_res.pc;
		step_res.acc_now    = alu_res.acc;
	end

	// control and memory port
	always_comb begin
		state_d       = state_q;
		pc_d          = pc_q;
		acc_d         = acc_q;
		lo_d          = lo_q;
		ram_en        = 1'b0;
		ram_we        = 1'b0;
		ram_addr      = '0;
		ram_wdata     = '0;
		stat          = '0;
		res           = '0;
		res.pc_now    = pc_q;
		res.acc_now   = acc_q;
		unique case (state_q)
			S_CLEAR: begin
				stat.clearing = 1'b1;
				ram_en        = 1'b1;
				ram_we        = 1'b1;
				ram_addr      = clr_q;
				if (clr_q == LAST_ADDR) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (item_full) begin
					unique case (item.operation)
						acs_pkg::REQ_WRITE: begin
							if (out_free) begin
								ram_en        = 1'b1;
								ram_we        = 1'b1;
								ram_addr      = item.address;
								ram_wdata     = item.byte_data;
								stat.take     = 1'b1;
								stat.res_load = 1'b1;
							end
						end
						acs_pkg::REQ_READ: begin
							ram_en    = 1'b1;
							ram_addr  = item.address;
							stat.take = 1'b1;
							state_d   = S_RD_DATA;
						end
						acs_pkg::REQ_STEP: begin
							ram_en    = 1'b1;
							ram_addr  = pc_q;
							stat.take = 1'b1;
							state_d   = S_FETCH_HI;
						end
						default: begin
							if (out_free) begin
								stat.take     = 1'b1;
								stat.res_load = 1'b1;
							end
						end
					endcase
				end
			end
			S_RD_DATA: begin
				res.read_data = ram_rdata;
				if (out_free) begin
					stat.res_load = 1'b1;
					state_d       = S_IDLE;
				end
			end
			S_FETCH_HI: begin
				ram_en   = 1'b1;
				ram_addr = pc_q + AW'(1);
				lo_d     = ram_rdata;
				state_d  = S_DECODE;
			end
			S_DECODE: begin
				if (mem_read_op) begin
					ram_en   = 1'b1;
					ram_addr = insn[AW-1:0];
					state_d  = S_OPER_HI;
				end else if (insn_opc == acs_pkg::OPC_STORE) begin
					ram_en    = 1'b1;
					ram_we    = 1'b1;
					ram_addr  = insn[AW-1:0];
					ram_wdata = acc_q[7:0];
					state_d   = S_STORE_HI;
				end else if (out_free) begin
					res           = step_res;
					stat.res_load = 1'b1;
					pc_d          = alu_res.pc;
					acc_d         = alu_res.acc;
					state_d       = S_IDLE;
				end
			end
			S_OPER_HI: begin
				ram_en   = 1'b1;
				ram_addr = operand_q + AW'(1);
				lo_d     = ram_rdata;
				state_d  = S_OPER_DAT;
			end
			S_OPER_DAT: begin
				if (out_free) begin
					res           = step_res;
					stat.res_load = 1'b1;
					pc_d          = alu_res.pc;
					acc_d         = alu_res.acc;
					state_d       = S_IDLE;
				end
			end
			S_STORE_HI: begin
				if (out_free) begin
					ram_en        = 1'b1;
					ram_we        = 1'b1;
					ram_addr      = operand_q + AW'(1);
					ram_wdata     = acc_q[15:8];
					res           = step_res;
					stat.res_load = 1'b1;
					pc_d          = alu_res.pc;
					acc_d         = alu_res.acc;
					state_d       = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// control state and architectural registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			pc_q    <= '0;
			acc_q   <= '0;
		end else begin
			state_q <= state_d;
			pc_q    <= pc_d;
			acc_q   <= acc_d;
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
		end
	end

	// working payload
	always_ff @(posedge clk) begin
		lo_q <= lo_d;
		if (state_q == S_DECODE) begin
			opcode_q  <= insn_opc;
			operand_q <= insn[AW-1:0];
		end
		if (stat.take) begin
			inval_q <= item.in_value;
		end
	end

	// a result is only loaded into a free output register
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		stat.res_load |-> out_free)
		else $error("result loaded while output register busy");

	// requests are only taken from a full holding register in idle
	a_take_idle: assert property (@(posedge clk) disable iff (!arst_n)
		stat.take |-> (item_full && state_q == S_IDLE))
		else $error("request taken outside idle");

	// the clearing pass only ever leaves toward idle
	a_clear_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR) |=> (state_q == S_CLEAR || state_q == S_IDLE))
		else $error("clearing pass left to a wrong state");

	// the high instruction byte fetch always follows a take in idle
	a_fetch_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FETCH_HI) |-> ($past(state_q) == S_IDLE && $past(stat.take)))
		else $error("fetch without a taken step request");

endmodule

>>> src/accumulator_cpu_step.sv
// top level of the accumulator processor step block
//
// Input channel (in_valid / in_stall): each request writes a memory byte,
// reads a memory byte or executes one instruction. A request is held in a
// one-entry register, so the next one is taken while a result still waits.
// Result channel (res_valid / res_stall): exactly one result per request,
// in request order, held in an output register while res_stall is high.
// Steps per request, once the sequencer takes it: a write completes as it is
// taken; a read addresses the byte, then returns it; an instruction fetches
// its low and high bytes, then decodes; a store then writes its high byte; a
// load or an arithmetic or logic op on memory reads both operand bytes. The
// single byte-wide memory port sets these steps: every instruction byte and
// operand byte is one access. After reset the memory is cleared one byte a
// cycle, and in_stall stays high meanwhile; pc and accumulator reset to zero.
// While res_stall holds the output register full, the sequencer finishes
// no further request and the holding register fills, raising in_stall.
module accumulator_cpu_step (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    operation,
	input  logic [acs_pkg::ADDR_W-1:0]    address,
	input  logic [7:0]                    byte_data,
	input  logic [15:0]                   in_value,
	output logic                          res_valid,
	input  logic                          res_stall,
	output logic [7:0]                    read_data,
	output logic                          halted,
	output logic                          in_used,
	output logic                          out_valid,
	output logic signed [15:0]            out_value,
	output logic [1:0]                    out_format,
	output logic [acs_pkg::ADDR_W-1:0]    pc_now,
	output logic signed [15:0]            acc_now
);

	acs_pkg::item_t     item_q;
	logic               item_full_q;
	acs_pkg::res_t      res_q;
	logic               res_full_q;
	acs_pkg::res_t      seq_res;
	acs_pkg::seq_stat_t stat;
	logic               out_free;
	logic               in_acc;

	// input holding register frees up in the cycle the sequencer takes it
	assign in_stall = stat.clearing || (item_full_q && !stat.take);
	assign in_acc   = in_valid && !in_stall;
	assign out_free = !res_full_q || !res_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_full_q <= 1'b0;
			res_full_q  <= 1'b0;
		end else begin
			if (in_acc) begin
				item_full_q <= 1'b1;
			end else if (stat.take) begin
				item_full_q <= 1'b0;
			end
			if (stat.res_load) begin
				res_full_q <= 1'b1;
			end else if (!res_stall) begin
				res_full_q <= 1'b0;
			end
		end
	end

	// request and result payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			item_q.operation <= operation;
			item_q.address   <= address;
			item_q.byte_data <= byte_data;
			item_q.in_value  <= in_value;
		end
		if (stat.res_load) begin
			res_q <= seq_res;
		end
	end

	acs_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item_q),
		.item_full (item_full_q),
		.out_free  (out_free),
		.res       (seq_res),
		.stat      (stat)
	);

	// result ports
	assign res_valid  = res_full_q;
	assign read_data  = res_q.read_data;
	assign halted     = res_q.halted;
	assign in_used    = res_q.in_used;
	assign out_valid  = res_q.out_valid;
	assign out_value  = res_q.out_value;
	assign out_format = res_q.out_format;
	assign pc_now     = res_q.pc_now;
	assign acc_now    = res_q.acc_now;

	// no request is accepted during the clearing pass
	a_no_acc_clear: assert property (@(posedge clk) disable iff (!arst_n)
		stat.clearing |-> !in_acc)
		else $error("request accepted during memory clear");

	// a waiting result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(res_full_q && res_stall) |-> !stat.res_load)
		else $error("stalled result overwritten");

	// the holding register is never overwritten while still full
	a_hold_safe: assert property (@(posedge clk) disable iff (!arst_n)
		(item_full_q && !stat.take) |-> !in_acc)
		else $error("holding register overwritten");

endmodule

>>> dv/accumulator_cpu_step_tb.sv
// self-checking testbench of the accumulator processor step block
module accumulator_cpu_step_tb;
	timeunit 1ns;
	timeprecision 1ps;

	// spare request code, treated as a no-op by the block
	localparam logic [1:0] REQ_SPARE = 2'd3;
	// which copy of the processor state a prediction runs on
	localparam int GEN_SIDE = 0;
	localparam int CHK_SIDE = 1;
	localparam int RANDOM_REQS = 700;
	localparam int MAX_GAP = 17;
	localparam int HOLD_CYCLES = 300;

	typedef struct {
		acs_pkg::item_t req;
		int             gap;
	} queued_req_t;

	logic                             clk = 1'b0;
	logic                             arst_n = 1'b0;
	logic                             in_valid = 1'b0;
	logic                             in_stall;
	logic [1:0]                       operation = '0;
	logic [acs_pkg::ADDR_W-1:0]       address = '0;
	logic [7:0]                       byte_data = '0;
	logic [15:0]                      in_value = '0;
	logic                             res_valid;
	logic                             res_stall = 1'b0;
	logic [7:0]                       read_data;
	logic                             halted;
	logic                             in_used;
	logic                             out_valid;
	logic signed [15:0]               out_value;
	logic [1:0]                       out_format;
	logic [acs_pkg::ADDR_W-1:0]       pc_now;
	logic signed [15:0]               acc_now;

	// two copies of the processor: one steers the stimulus, one checks
	logic [7:0]                       mem_img [2][acs_pkg::MEM_BYTES];
	logic signed [15:0]               acc_img [2];
	logic [acs_pkg::ADDR_W-1:0]       pc_img [2];

	queued_req_t                      pending_reqs [$];
	acs_pkg::res_t                    predicted_results [$];
	queued_req_t                      nxt_entry;
	acs_pkg::item_t                   on_port;
	acs_pkg::res_t                    want;
	int                               gap_waited = 0;
	int                               stall_left = 0;
	int                               results_seen = 0;
	int                               next_hold_at = 150;
	int                               hold_left = 0;
	int                               req_count = 0;
	int                               mismatches = 0;
	bit                               sender_calm = 1'b0;
	bit                               receiver_calm = 1'b0;
	logic                             long_hold;

	accumulator_cpu_step DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.operation  (operation),
		.address    (address),
		.byte_data  (byte_data),
		.in_value   (in_value),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.read_data  (read_data),
		.halted     (halted),
		.in_used    (in_used),
		.out_valid  (out_valid),
		.out_value  (out_value),
		.out_format (out_format),
		.pc_now     (pc_now),
		.acc_now    (acc_now)
	);

	// clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// little-endian word, high byte address wraps past the top
	function automatic logic [15:0] word_at(int side, logic [acs_pkg::ADDR_W-1:0] lo);
		logic [acs_pkg::ADDR_W-1:0] hi;
		hi = lo + 12'd1;
		return {mem_img[side][hi], mem_img[side][lo]};
	endfunction

	// apply one request to a processor copy and return its result
	function automatic acs_pkg::res_t step_cpu(int side, acs_pkg::item_t rq);
		acs_pkg::res_t                 r;
		logic [15:0]                   insn;
		acs_pkg::opcode_t              opc;
		logic [acs_pkg::ADDR_W-1:0]    opnd;
		logic [acs_pkg::ADDR_W-1:0]    nxt;
		logic [acs_pkg::ADDR_W-1:0]    hi;
		logic signed [15:0]            a;
		r = '0;
		case (rq.operation)
		acs_pkg::REQ_WRITE: mem_img[side][rq.address] = rq.byte_data;
		acs_pkg::REQ_READ: r.read_data = mem_img[side][rq.address];
		acs_pkg::REQ_STEP: begin
			insn = word_at(side, pc_img[side]);
			opc = acs_pkg::opcode_t'(insn[15:12]);
			opnd = insn[11:0];
			nxt = pc_img[side] + 12'd2;
			a = acc_img[side];
			case (opc)
			acs_pkg::OPC_HALT: r.halted = 1'b1;
			acs_pkg::OPC_NOT: a = ~a;
			// shifts past the width give zero or sign fill
			acs_pkg::OPC_SHL: a = a << opnd;
			acs_pkg::OPC_SAR: a = a >>> opnd;
			acs_pkg::OPC_INC: a = a + 16'sd1;
			acs_pkg::OPC_DEC: a = a - 16'sd1;
			acs_pkg::OPC_JMP: nxt = opnd;
			acs_pkg::OPC_JAZ: if (a == 16'sd0) nxt = opnd;
			acs_pkg::OPC_LOAD: a = word_at(side, opnd);
			acs_pkg::OPC_STORE: begin
				hi = opnd + 12'd1;
				mem_img[side][opnd] = a[7:0];
				mem_img[side][hi] = a[15:8];
			end
			acs_pkg::OPC_ADD: a = a + word_at(side, opnd);
			acs_pkg::OPC_AND: a = a & word_at(side, opnd);
			acs_pkg::OPC_OR: a = a | word_at(side, opnd);
			acs_pkg::OPC_XOR: a = a ^ word_at(side, opnd);
			acs_pkg::OPC_OUT: begin
				r.out_valid = 1'b1;
				r.out_value = a;
				r.out_format = (opnd >= 12'd2) ? acs_pkg::FMT_CHAR : opnd[1:0];
			end
			acs_pkg::OPC_IN: begin
				a = rq.in_value;
				r.in_used = 1'b1;
			end
			endcase
			acc_img[side] = a;
			pc_img[side] = nxt;
		end
		// spare code leaves all state alone
		default: ;
		endcase
		r.pc_now = pc_img[side];
		r.acc_now = acc_img[side];
		return r;
	endfunction

	// operand addresses cluster in a small data area and the top byte
	function automatic logic [acs_pkg::ADDR_W-1:0] operand_addr();
		if ($urandom_range(0, 9) < 7)
			return 12'hF00 + 12'($urandom_range(0, 31));
		else if ($urandom_range(0, 1) == 0)
			return 12'hFFF;
		return 12'($urandom);
	endfunction

	task automatic queue_req(logic [1:0] op, logic [acs_pkg::ADDR_W-1:0] addr,
			logic [7:0] data, logic [15:0] inval);
		queued_req_t e;
		e.req.operation = op;
		e.req.address = addr;
		e.req.byte_data = data;
		e.req.in_value = inval;
		e.gap = sender_calm ? 0 : $urandom_range(0, MAX_GAP);
		pending_reqs.push_back(e);
		void'(step_cpu(GEN_SIDE, e.req));
		if (op != REQ_SPARE)
			req_count++;
	endtask

	// place one instruction word as two byte writes
	task automatic queue_insn(logic [acs_pkg::ADDR_W-1:0] loc, acs_pkg::opcode_t opc,
			logic [acs_pkg::ADDR_W-1:0] opnd);
		logic [15:0] word;
		word = {opc, opnd};
		queue_req(acs_pkg::REQ_WRITE, loc, word[7:0], 16'($urandom));
		queue_req(acs_pkg::REQ_WRITE, loc + 12'd1, word[15:8], 16'($urandom));
	endtask

	task automatic report_mismatch(string msg);
		if (mismatches < 200)
			$display("mismatch at %0t: %s", $realtime, msg);
		mismatches++;
	endtask

	task automatic check_field(string name, logic [15:0] got, logic [15:0] exp_val);
		if (got !== exp_val)
			report_mismatch($sformatf("%s got %h expected %h", name, got, exp_val));
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			gap_waited = 0;
		end else begin
			if (in_valid && !in_stall)
				predicted_results.push_back(step_cpu(CHK_SIDE, on_port));
			if (!in_valid || !in_stall) begin
				if (pending_reqs.size() != 0 && gap_waited >= pending_reqs[0].gap) begin
					nxt_entry = pending_reqs.pop_front();
					on_port = nxt_entry.req;
					in_valid <= 1'b1;
					operation <= on_port.operation;
					address <= on_port.address;
					byte_data <= on_port.byte_data;
					in_value <= on_port.in_value;
					gap_waited = 0;
				end else begin
					in_valid <= 1'b0;
					if (pending_reqs.size() != 0)
						gap_waited++;
				end
			end
		end
	end

	// long receiver hold-off so the block backs up into its input
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			next_hold_at <= 150;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (results_seen >= next_hold_at) begin
			hold_left <= HOLD_CYCLES;
			next_hold_at <= next_hold_at + HOLD_CYCLES;
		end
	end

	assign long_hold = (hold_left != 0);

	// result monitor and stall generator
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_stall <= 1'b0;
			stall_left = 0;
		end else begin
			if (res_valid && !res_stall) begin
				if (predicted_results.size() == 0) begin
					report_mismatch("result with no request outstanding");
				end else begin
					want = predicted_results.pop_front();
					check_field("read_data", read_data, want.read_data);
					check_field("halted", halted, want.halted);
					check_field("in_used", in_used, want.in_used);
					check_field("out_valid", out_valid, want.out_valid);
					check_field("out_value", out_value, want.out_value);
					check_field("out_format", out_format, want.out_format);
					check_field("pc_now", pc_now, want.pc_now);
					check_field("acc_now", acc_now, want.acc_now);
				end
				results_seen <= results_seen + 1;
				if (results_seen % 40 == 0)
					receiver_calm = ($urandom_range(0, 4) == 0);
				stall_left = receiver_calm ? 0 : $urandom_range(0, MAX_GAP);
			end else if (stall_left != 0) begin
				stall_left--;
			end
			res_stall <= long_hold || (stall_left != 0);
		end
	end

	// run limit
	initial begin
		#5_000_000;
		$display("tb: failure");
		$finish;
	end

	// stimulus, reset and end of run
	initial begin : stimulus
		logic [acs_pkg::ADDR_W-1:0] base;
		logic [acs_pkg::ADDR_W-1:0] opnd;
		acs_pkg::opcode_t           opc;
		int                         len;
		for (int s = 0; s < 2; s++) begin
			for (int k = 0; k < acs_pkg::MEM_BYTES; k++)
				mem_img[s][k] = 8'h00;
			acc_img[s] = '0;
			pc_img[s] = '0;
		end

		// directed: spare code, word wrap at the top address, large shifts
		queue_req(REQ_SPARE, 12'hFFF, 8'hFF, 16'hFFFF);
		queue_insn(12'h000, acs_pkg::OPC_JMP, 12'h1FE);
		queue_req(acs_pkg::REQ_WRITE, 12'hFFF, 8'h80, 16'h0000);
		queue_insn(12'h1FE, acs_pkg::OPC_LOAD, 12'hFFF);
		queue_insn(12'h200, acs_pkg::OPC_SAR, 12'd16);
		queue_insn(12'h202, acs_pkg::OPC_STORE, 12'hFFF);
		queue_insn(12'h204, acs_pkg::OPC_OUT, 12'hFFF);
		queue_insn(12'h206, acs_pkg::OPC_SHL, 12'd16);
		queue_insn(12'h208, acs_pkg::OPC_IN, 12'h000);
		repeat (6)
			queue_req(acs_pkg::REQ_STEP, 12'h000, 8'h00, 16'h0000);
		queue_req(acs_pkg::REQ_STEP, 12'hFFF, 8'hFF, 16'hFFFF);
		queue_req(acs_pkg::REQ_READ, 12'h000, 8'h00, 16'h0000);
		queue_req(acs_pkg::REQ_READ, 12'hFFF, 8'hFF, 16'hFFFF);

		// random: mostly short programs at the current pc, then stepped
		while (req_count < RANDOM_REQS) begin
			sender_calm = ($urandom_range(0, 5) == 0);
			if ($urandom_range(0, 9) < 8) begin
				repeat ($urandom_range(0, 3))
					queue_req(acs_pkg::REQ_WRITE, operand_addr(), 8'($urandom),
						16'($urandom));
				len = $urandom_range(1, 8);
				base = pc_img[GEN_SIDE];
				for (int i = 0; i < len; i++) begin
					opc = acs_pkg::opcode_t'(4'($urandom_range(0, 15)));
					case (opc)
					acs_pkg::OPC_SHL, acs_pkg::OPC_SAR:
						opnd = ($urandom_range(0, 3) != 0) ? 12'($urandom_range(0, 20))
							: 12'($urandom);
					acs_pkg::OPC_LOAD, acs_pkg::OPC_STORE, acs_pkg::OPC_ADD,
					acs_pkg::OPC_AND, acs_pkg::OPC_OR, acs_pkg::OPC_XOR:
						opnd = operand_addr();
					acs_pkg::OPC_JMP, acs_pkg::OPC_JAZ:
						opnd = ($urandom_range(0, 3) != 0)
							? base + 12'(2 * $urandom_range(0, len)) : 12'($urandom);
					acs_pkg::OPC_OUT:
						opnd = ($urandom_range(0, 3) != 0) ? 12'($urandom_range(0, 3))
							: 12'($urandom);
					default: opnd = 12'($urandom);
					endcase
					queue_insn(base + 12'(2 * i), opc, opnd);
				end
				repeat (len + $urandom_range(0, 2)) begin
					if ($urandom_range(0, 7) == 0)
						queue_req(acs_pkg::REQ_READ, operand_addr(), 8'($urandom),
							16'($urandom));
					queue_req(acs_pkg::REQ_STEP, 12'($urandom), 8'($urandom),
						($urandom_range(0, 3) == 0) ? 16'h0000 : 16'($urandom));
				end
			end else begin
				// noise: any code with any fields
				queue_req(2'($urandom_range(0, 3)), 12'($urandom), 8'($urandom),
					16'($urandom));
			end
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// drain, then give the block time to show any stray result
		while (pending_reqs.size() != 0 || in_valid || predicted_results.size() != 0)
			@(negedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
